@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// expression must never be true out of reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

@@ hdl/pgftd_pkg.sv @@
// ---------------------------------------------------------------------------
// pgftd_pkg
// Constants, codes and controller/datapath interface types of the
// pressure grid frame touch decoder.
// ---------------------------------------------------------------------------
package pgftd_pkg;

    localparam int FRAME_BYTES  = 35;
    localparam int SENSOR_COUNT = 16;
    localparam int POS_W        = $clog2(FRAME_BYTES);
    localparam int IDX_W        = $clog2(SENSOR_COUNT);

    localparam logic [7:0] HEAD_FIRST  = 8'hAA;
    localparam logic [7:0] HEAD_SECOND = 8'h01;

    localparam logic [2:0] NO_ROW = 3'd4;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_DOWN = 2'd1;
    localparam logic [1:0] DIR_UP   = 2'd2;

    localparam logic [1:0] PB_UNKNOWN = 2'd2;

    localparam logic [2:0] CFG_ZP_BOTTOM = 3'd0;
    localparam logic [2:0] CFG_ZP_LOWER  = 3'd1;
    localparam logic [2:0] CFG_ZP_UPPER  = 3'd2;
    localparam logic [2:0] CFG_ZP_TOP    = 3'd3;
    localparam logic [2:0] CFG_COMP_EN   = 3'd4;
    localparam logic [2:0] CFG_DEAD_ZONE = 3'd5;
    localparam logic [2:0] CFG_HEAVY     = 3'd6;
    localparam logic [2:0] CFG_TOUCH_EN  = 3'd7;

    localparam logic [15:0] DEAD_ZONE_RST = 16'd50;
    localparam logic [15:0] HEAVY_RST     = 16'd1000;

    typedef struct packed {
        logic             sum_load;
        logic             sum_add;
        logic             hold_hi;
        logic             write_lo;
        logic [IDX_W-1:0] wr_idx;
        logic             clr_stats;
        logic             load_val;
        logic [IDX_W-1:0] rd_idx;
        logic             acc;
        logic             out_data;
        logic             out_err;
        logic             fin;
    } t_dp_cmd;

    typedef struct packed {
        logic is_head1;
        logic is_head2;
        logic sum_ok;
        logic out_free;
    } t_dp_sts;

endpackage

@@ hdl/pressure_grid_frame_touch_decoder.sv @@
// ---------------------------------------------------------------------------
// pressure_grid_frame_touch_decoder
// Serial byte stream in, per-sensor pressures and a touch report out.
// ---------------------------------------------------------------------------
// Input channel: one received byte per request (i_rx_valid / o_rx_stall).
// Bytes are taken one per cycle while a frame is being collected. After the
// checksum byte the input is stalled until the frame's results are loaded.
// Output channel: one result per request (o_res_valid / i_res_stall), held
// in an output register, so a byte may be taken while the last result waits.
// A bad checksum gives one error result, loaded once the output is free.
// A good frame gives 16 results in turn: each pressure is read and
// compensated, folded into the frame statistics, then loaded once the
// output is free, so a stalled receiver holds the burst in place.
// Configuration writes take effect at the next edge and must be made while
// the block is idle. Reset is synchronous: the header hunt restarts, the
// configuration returns to its defaults and the touch history is cleared.
// ---------------------------------------------------------------------------
module pressure_grid_frame_touch_decoder
    import pgftd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rx_valid,
    output logic             o_rx_stall,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [63:0]      i_cfg_data,
    output logic             o_res_valid,
    input  logic             i_res_stall,
    output logic             o_frame_status,
    output logic [IDX_W-1:0] o_sensor_index,
    output logic [15:0]      o_pressure,
    output logic             o_last,
    output logic             o_pressed,
    output logic             o_status_changed,
    output logic             o_touch_valid,
    output logic             o_intensity,
    output logic [1:0]       o_direction,
    output logic [15:0]      o_peak_pressure
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    pgftd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_stall (o_rx_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pgftd_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rx_byte        (i_rx_byte),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_res_stall      (i_res_stall),
        .o_res_valid      (o_res_valid),
        .o_frame_status   (o_frame_status),
        .o_sensor_index   (o_sensor_index),
        .o_pressure       (o_pressure),
        .o_last           (o_last),
        .o_pressed        (o_pressed),
        .o_status_changed (o_status_changed),
        .o_touch_valid    (o_touch_valid),
        .o_intensity      (o_intensity),
        .o_direction      (o_direction),
        .o_peak_pressure  (o_peak_pressure)
    );

endmodule

@@ hdl/pgftd_ctrl.sv @@
// ---------------------------------------------------------------------------
// pgftd_ctrl
// Frame sequencer: header hunt, byte position, checksum decision and the
// load / accumulate / output steps of the result burst.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pgftd_ctrl
    import pgftd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_rx_valid,
    output logic    o_rx_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] ST_RX   = 3'd0;
    localparam logic [2:0] ST_ERR  = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SENSOR_COUNT - 1);

    logic [2:0]       r_state, n_state;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [POS_W-1:0] data_off;
    logic             rx_take;

    assign o_rx_stall = (r_state != ST_RX);
    assign rx_take    = i_rx_valid && (r_state == ST_RX);
    assign data_off   = r_pos - POS_W'(2);

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_cmd.wr_idx = IDX_W'(data_off >> 1);
        o_cmd.rd_idx = r_idx;
        o_cmd.fin    = (r_idx == IDX_LAST);
        unique case (r_state)
            ST_RX: begin
                if (rx_take) begin
                    if (r_pos == '0) begin
                        if (i_sts.is_head1) begin
                            n_pos = POS_W'(1);
                            o_cmd.sum_load = 1'b1;
                        end
                    end else if (r_pos == POS_W'(1)) begin
                        if (i_sts.is_head2) begin
                            n_pos = POS_W'(2);
                            o_cmd.sum_add = 1'b1;
                        end else if (i_sts.is_head1) begin
                            o_cmd.sum_load = 1'b1;
                        end else begin
                            n_pos = '0;
                        end
                    end else if (r_pos != POS_LAST) begin
                        o_cmd.sum_add  = 1'b1;
                        o_cmd.hold_hi  = ~data_off[0];
                        o_cmd.write_lo = data_off[0];
                        n_pos = r_pos + POS_W'(1);
                    end else begin
                        n_pos = '0;
                        if (i_sts.sum_ok) begin
                            o_cmd.clr_stats = 1'b1;
                            n_idx   = '0;
                            n_state = ST_LOAD;
                        end else begin
                            n_state = ST_ERR;
                        end
                    end
                end
            end
            ST_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.out_err = 1'b1;
                    n_state = ST_RX;
                end
            end
            ST_LOAD: begin
                o_cmd.load_val = 1'b1;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_data = 1'b1;
                    if (r_idx == IDX_LAST) begin
                        n_state = ST_RX;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_RX;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RX;
            r_pos   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_idx   <= n_idx;
        end
    end

    `ASSERT_NEVER(a_load_when_free, (o_cmd.out_data || o_cmd.out_err) && !i_sts.out_free, "result loaded into busy output")
    `ASSERT_NEVER(a_pos_range, r_pos > POS_LAST, "frame position out of range")
    `ASSERT_PROP(a_fin_returns, (o_cmd.out_data && o_cmd.fin) |=> (r_state == ST_RX), "burst did not end")
    `ASSERT_NEVER(a_pos_idle_burst, (r_state != ST_RX) && (r_pos != '0), "position moved during burst")

endmodule

@@ hdl/pgftd_dp.sv @@
// ---------------------------------------------------------------------------
// pgftd_dp
// Datapath: configuration registers, checksum, pressure buffer, zero-point
// compensation, frame statistics, touch report and the output register.
// ---------------------------------------------------------------------------
module pgftd_dp
    import pgftd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [63:0]      i_cfg_data,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    input  logic             i_res_stall,
    output logic             o_res_valid,
    output logic             o_frame_status,
    output logic [IDX_W-1:0] o_sensor_index,
    output logic [15:0]      o_pressure,
    output logic             o_last,
    output logic             o_pressed,
    output logic             o_status_changed,
    output logic             o_touch_valid,
    output logic             o_intensity,
    output logic [1:0]       o_direction,
    output logic [15:0]      o_peak_pressure
);

    logic [3:0][3:0][15:0] r_zp;
    logic                  r_comp_en;
    logic [15:0]           r_dead;
    logic [15:0]           r_heavy;
    logic                  r_touch_en;

    logic [7:0]            r_sum;
    logic [7:0]            r_hi;
    logic [15:0]           r_buf [SENSOR_COUNT];

    logic [15:0]           r_val;
    logic [IDX_W-1:0]      r_vidx;
    logic [15:0]           r_max;
    logic                  r_press;
    logic [3:0]            r_rowhit;
    logic [1:0]            r_pb;
    logic [2:0]            r_row_now;

    logic                  r_out_valid;
    logic                  r_o_status;
    logic [IDX_W-1:0]      r_o_idx;
    logic [15:0]           r_o_press;
    logic                  r_o_last;
    logic                  r_o_pressed;
    logic                  r_o_changed;
    logic                  r_o_tvalid;
    logic                  r_o_inten;
    logic [1:0]            r_o_dir;
    logic [15:0]           r_o_max;

    logic [15:0]           raw;
    logic [15:0]           zp;
    logic [15:0]           comp_val;
    logic                  changed;
    logic                  tvalid;
    logic                  inten;
    logic [2:0]            row;
    logic                  row_move;
    logic [1:0]            dir;

    assign o_sts.is_head1 = (i_rx_byte == HEAD_FIRST);
    assign o_sts.is_head2 = (i_rx_byte == HEAD_SECOND);
    assign o_sts.sum_ok   = (i_rx_byte == r_sum);
    assign o_sts.out_free = !r_out_valid || !i_res_stall;

    assign raw      = r_buf[i_cmd.rd_idx];
    assign zp       = r_zp[i_cmd.rd_idx[3:2]][i_cmd.rd_idx[1:0]];
    assign comp_val = !r_comp_en ? raw : ((raw > zp) ? raw - zp : 16'd0);

    always_comb begin
        if (r_rowhit[3]) begin
            row = 3'd3;
        end else if (r_rowhit[2]) begin
            row = 3'd2;
        end else if (r_rowhit[1]) begin
            row = 3'd1;
        end else if (r_rowhit[0]) begin
            row = 3'd0;
        end else begin
            row = NO_ROW;
        end
    end

    assign changed  = (r_pb == PB_UNKNOWN) || (r_pb != {1'b0, r_press});
    assign tvalid   = r_press && r_touch_en;
    assign inten    = tvalid && (r_max >= r_heavy);
    assign row_move = tvalid && (row != NO_ROW) && (row != r_row_now);
    assign dir      = (!row_move || (r_row_now == NO_ROW)) ? DIR_NONE :
                      ((r_row_now < row) ? DIR_DOWN : DIR_UP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zp        <= '0;
            r_comp_en   <= 1'b0;
            r_dead      <= DEAD_ZONE_RST;
            r_heavy     <= HEAVY_RST;
            r_touch_en  <= 1'b1;
            r_pb        <= PB_UNKNOWN;
            r_row_now   <= NO_ROW;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx) inside
                    CFG_ZP_BOTTOM, CFG_ZP_LOWER, CFG_ZP_UPPER, CFG_ZP_TOP: begin
                        r_zp[i_cfg_idx[1:0]] <= i_cfg_data;
                    end
                    CFG_COMP_EN:   r_comp_en  <= i_cfg_data[0];
                    CFG_DEAD_ZONE: r_dead     <= i_cfg_data[15:0];
                    CFG_HEAVY:     r_heavy    <= i_cfg_data[15:0];
                    CFG_TOUCH_EN:  r_touch_en <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.out_data && i_cmd.fin) begin
                r_pb <= {1'b0, r_press};
                if (row_move) begin
                    r_row_now <= row;
                end
            end
            if (i_cmd.out_data || i_cmd.out_err) begin
                r_out_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_load) begin
            r_sum <= i_rx_byte;
        end else if (i_cmd.sum_add) begin
            r_sum <= r_sum + i_rx_byte;
        end
        if (i_cmd.hold_hi) begin
            r_hi <= i_rx_byte;
        end
        if (i_cmd.write_lo) begin
            r_buf[i_cmd.wr_idx] <= {r_hi, i_rx_byte};
        end
        if (i_cmd.load_val) begin
            r_val  <= comp_val;
            r_vidx <= i_cmd.rd_idx;
        end
        if (i_cmd.clr_stats) begin
            r_max    <= '0;
            r_press  <= 1'b0;
            r_rowhit <= '0;
        end else if (i_cmd.acc) begin
            if (r_val > r_dead) begin
                r_press <= 1'b1;
                r_rowhit[~r_vidx[3:2]] <= 1'b1;
            end
            if (r_val > r_max) begin
                r_max <= r_val;
            end
        end
        if (i_cmd.out_err) begin
            r_o_status  <= 1'b1;
            r_o_idx     <= '0;
            r_o_press   <= '0;
            r_o_last    <= 1'b1;
            r_o_pressed <= 1'b0;
            r_o_changed <= 1'b0;
            r_o_tvalid  <= 1'b0;
            r_o_inten   <= 1'b0;
            r_o_dir     <= DIR_NONE;
            r_o_max     <= '0;
        end else if (i_cmd.out_data) begin
            r_o_status  <= 1'b0;
            r_o_idx     <= r_vidx;
            r_o_press   <= r_val;
            r_o_last    <= i_cmd.fin;
            r_o_pressed <= i_cmd.fin && r_press;
            r_o_changed <= i_cmd.fin && changed;
            r_o_tvalid  <= i_cmd.fin && tvalid;
            r_o_inten   <= i_cmd.fin && inten;
            r_o_dir     <= i_cmd.fin ? dir : DIR_NONE;
            r_o_max     <= i_cmd.fin ? r_max : 16'd0;
        end
    end

    assign o_res_valid      = r_out_valid;
    assign o_frame_status   = r_o_status;
    assign o_sensor_index   = r_o_idx;
    assign o_pressure       = r_o_press;
    assign o_last           = r_o_last;
    assign o_pressed        = r_o_pressed;
    assign o_status_changed = r_o_changed;
    assign o_touch_valid    = r_o_tvalid;
    assign o_intensity      = r_o_inten;
    assign o_direction      = r_o_dir;
    assign o_peak_pressure  = r_o_max;

endmodule
